// ----- src/keyed_mod223_byte_cipher_defines.svh -----
// Assertion macros for the RTL of the keyed mod-223 byte cipher; used by kmbc_datapath.
// The using module must have a clock named clk and a synchronous reset named rst.
`ifndef KEYED_MOD223_BYTE_CIPHER_DEFINES_SVH
`define KEYED_MOD223_BYTE_CIPHER_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define KMBC_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("kmbc: invariant violated");

// Property whose consequent must hold in the cycle after the antecedent.
`define KMBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kmbc: next-cycle check failed");

`endif

// ----- src/kmbc_pkg.sv -----
// Shared constants, types and the modular inverse function of the byte cipher.
// No dependencies; every other file but the macro header refers to it by scoped names.
package kmbc_pkg;

  localparam int KEY_LENGTH_DEFAULT = 80;

  localparam int BYTE_W      = 8;
  localparam int DIGIT_W     = 4;
  localparam int ROW_DIGITS  = 10;
  localparam int ROW_COUNT   = 8;
  localparam int ROW_IDX_W   = 3;
  localparam int COL_W       = 4;
  localparam int ROW_W       = DIGIT_W * ROW_DIGITS;
  localparam int WINDOW_W    = ROW_W + DIGIT_W;

  localparam int APB_ADDR_W  = 6;
  localparam int APB_DATA_W  = 64;
  localparam int ADDR_LSB    = 3;

  localparam int MODULUS     = 223;
  localparam int OFFSET      = 31;
  localparam int U_W         = 8;
  localparam int PROD_W      = 16;

  // floor(2^24 / 223); quotient estimate is low by at most one
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP       = (1 << RECIP_SHIFT) / MODULUS;
  localparam int RECIP_W     = $clog2(RECIP + 1);
  localparam int QPROD_W     = PROD_W + RECIP_W;

  typedef logic [ROW_W-1:0]     key_row_t;
  typedef logic [WINDOW_W-1:0]  key_window_t;
  typedef logic [ROW_IDX_W-1:0] row_idx_t;

  // a^(p-2) mod p; only evaluated on constants to fill the inverse table
  function automatic logic [BYTE_W-1:0] inv_mod(input int unsigned a);
    int unsigned r;
    int unsigned b;
    int unsigned e;
    r = 1;
    b = a % MODULUS;
    e = MODULUS - 2;
    while (e != 0) begin
      if (e[0]) r = (r * b) % MODULUS;
      b = (b * b) % MODULUS;
      e = e >> 1;
    end
    return r[BYTE_W-1:0];
  endfunction

endpackage

// ----- src/kmbc_ifs.sv -----
// Valid/ready stream interfaces for the byte cipher input and result channels.
// Depends on kmbc_pkg for the byte width.
interface kmbc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [kmbc_pkg::BYTE_W-1:0] data_byte;
  logic                        last;

  modport source (output valid, kind, data_byte, last, input ready);
  modport sink   (input valid, kind, data_byte, last, output ready);
endinterface

interface kmbc_out_if;
  logic                        valid;
  logic                        ready;
  logic [kmbc_pkg::BYTE_W-1:0] out_byte;
  logic                        out_last;

  modport source (output valid, out_byte, out_last, input ready);
  modport sink   (input valid, out_byte, out_last, output ready);
endinterface

// ----- src/keyed_mod223_byte_cipher.sv -----
// Keyed mod-223 byte cipher: top level, joins the key registers and the datapath.
// Depends on kmbc_pkg, kmbc_ifs, kmbc_key_regs and kmbc_datapath.
//
// Usage:
//   din   - valid/ready channel; one beat carries kind (0 encrypt, 1 decrypt),
//           data_byte and last. last rewinds the key position to digit 0.
//   dout  - valid/ready channel; one beat per input beat with out_byte and
//           out_last, in input order.
//   APB   - key rows at byte addresses 8*k, k = 0..7, ten 4-bit digits per
//           row in bits 39:0. pready is tied high; write only while idle.
// Pipeline: 4 register stages (key select, multiply, reciprocal multiply,
//   remainder and output register) lie between an accepted input beat and
//   its result.
// Throughput: one beat per cycle while dout is not held; each stage has its
//   own ready, so bubbles collapse.
// Reset: synchronous; clears the key rows, the key position and all valid
//   flags. The block accepts beats the cycle after reset is released.
// Stall: when dout is held, results stay in place and din keeps accepting
//   until the four stages are full, then ready drops.
module keyed_mod223_byte_cipher #(
  parameter int KEY_LENGTH = kmbc_pkg::KEY_LENGTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  kmbc_in_if.sink                          din,
  kmbc_out_if.source                       dout,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [kmbc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [kmbc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [kmbc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  kmbc_pkg::row_idx_t    row_rd;
  kmbc_pkg::key_window_t window;

  kmbc_key_regs u_key_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .row_rd  (row_rd),
    .window  (window)
  );

  kmbc_datapath #(
    .KEY_LENGTH (KEY_LENGTH)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .din    (din),
    .dout   (dout),
    .row_rd (row_rd),
    .window (window)
  );

endmodule

// ----- src/kmbc_key_regs.sv -----
// APB key register file: eight rows of ten key digits, plus a registered
// digit window for the datapath. Depends on kmbc_pkg.
module kmbc_key_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [kmbc_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [kmbc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [kmbc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  input  kmbc_pkg::row_idx_t                  row_rd,
  output kmbc_pkg::key_window_t               window
);

  kmbc_pkg::key_row_t                rows [kmbc_pkg::ROW_COUNT];
  // nxt[k] mirrors digit 0 of row k+1; last entry stays zero (digit 80)
  logic [kmbc_pkg::DIGIT_W-1:0]      nxt  [kmbc_pkg::ROW_COUNT];

  logic                              wr;
  kmbc_pkg::row_idx_t                widx;
  kmbc_pkg::row_idx_t                rd_plus;
  kmbc_pkg::key_row_t                wdata;
  kmbc_pkg::key_row_t                win_row;
  logic [kmbc_pkg::DIGIT_W-1:0]      win_nxt;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign widx    = paddr[kmbc_pkg::APB_ADDR_W-1:kmbc_pkg::ADDR_LSB];
  assign wdata   = pwdata[kmbc_pkg::ROW_W-1:0];
  assign rd_plus = row_rd + kmbc_pkg::ROW_IDX_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < kmbc_pkg::ROW_COUNT; k++) begin
        rows[k] <= '0;
        nxt[k]  <= '0;
      end
    end else if (wr) begin
      rows[widx] <= wdata;
      if (widx != '0) begin
        nxt[widx - kmbc_pkg::ROW_IDX_W'(1)] <= wdata[kmbc_pkg::DIGIT_W-1:0];
      end
    end
  end

  // forward a write landing in the same cycle so the window is never stale
  always_comb begin
    win_row = (wr && widx == row_rd) ? wdata : rows[row_rd];
    if (row_rd == kmbc_pkg::ROW_IDX_W'(kmbc_pkg::ROW_COUNT - 1)) begin
      win_nxt = '0;
    end else if (wr && widx == rd_plus) begin
      win_nxt = wdata[kmbc_pkg::DIGIT_W-1:0];
    end else begin
      win_nxt = nxt[row_rd];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else begin
      window <= {win_nxt, win_row};
    end
  end

  // address is stable in the setup cycle, so data is ready for the access cycle
  always_ff @(posedge clk) begin
    prdata <= kmbc_pkg::APB_DATA_W'(rows[widx]);
  end

endmodule

// ----- src/kmbc_datapath.sv -----
// Key position tracking and the four-register cipher pipeline.
// Depends on kmbc_pkg, kmbc_ifs and the assertion macro header.
`include "keyed_mod223_byte_cipher_defines.svh"

module kmbc_datapath #(
  parameter int KEY_LENGTH = kmbc_pkg::KEY_LENGTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  kmbc_in_if.sink               din,
  kmbc_out_if.source            dout,
  output kmbc_pkg::row_idx_t    row_rd,
  input  kmbc_pkg::key_window_t window
);

  localparam int POS_W     = (KEY_LENGTH > 1) ? $clog2(KEY_LENGTH) : 1;
  localparam int INV_DEPTH = 1 << kmbc_pkg::U_W;

  // key position, kept also as row/column of the digit registers
  logic [POS_W-1:0]           pos, pos_next;
  kmbc_pkg::row_idx_t         row, row_next;
  logic [kmbc_pkg::COL_W-1:0] col, col_next;

  logic accept;
  logic rdy0, rdy1, rdy2, rdy3;

  // stage 0: multiplier and raw byte
  logic                        v0;
  logic [kmbc_pkg::U_W-1:0]    u0;
  logic                        kind0;
  logic [kmbc_pkg::BYTE_W-1:0] x0;
  logic                        last0;
  // stage 1: product magnitude
  logic                        v1;
  logic [kmbc_pkg::PROD_W-1:0] a1;
  logic                        neg1;
  logic                        last1;
  // stage 2: quotient estimate
  logic                        v2;
  logic [kmbc_pkg::PROD_W-1:0] a2;
  logic [kmbc_pkg::BYTE_W-1:0] q2;
  logic                        neg2;
  logic                        last2;

  // constant table of inverses mod 223, one entry per multiplier value
  logic [kmbc_pkg::BYTE_W-1:0]  inv_rom [INV_DEPTH];

  logic [kmbc_pkg::DIGIT_W-1:0] d_hi, d_lo;
  logic [kmbc_pkg::U_W-1:0]     u_calc;
  logic [kmbc_pkg::U_W-1:0]     m1;
  logic [kmbc_pkg::BYTE_W-1:0]  mag1;
  logic [kmbc_pkg::QPROD_W-1:0] qprod;
  logic [kmbc_pkg::PROD_W-1:0]  rem_raw;
  logic [kmbc_pkg::BYTE_W-1:0]  rem3;
  logic [kmbc_pkg::BYTE_W-1:0]  res3;

  for (genvar g = 0; g < INV_DEPTH; g++) begin : g_inv_rom
    assign inv_rom[g] = kmbc_pkg::inv_mod(g);
  end

  assign accept = din.valid && din.ready;

  // per-stage ready so bubbles collapse
  assign rdy3      = !dout.valid || dout.ready;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign rdy0      = !v0 || rdy1;
  assign din.ready = rdy0 && !rst;

  always_comb begin
    pos_next = pos;
    row_next = row;
    col_next = col;
    if (accept) begin
      if (din.last || pos == POS_W'(KEY_LENGTH - 1)) begin
        pos_next = '0;
        row_next = '0;
        col_next = '0;
      end else begin
        pos_next = pos + POS_W'(1);
        if (col == kmbc_pkg::COL_W'(kmbc_pkg::ROW_DIGITS - 1)) begin
          col_next = '0;
          row_next = row + kmbc_pkg::ROW_IDX_W'(1);
        end else begin
          col_next = col + kmbc_pkg::COL_W'(1);
        end
      end
    end
  end

  assign row_rd = row_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      row <= '0;
      col <= '0;
    end else begin
      pos <= pos_next;
      row <= row_next;
      col <= col_next;
    end
  end

  // window holds the current row plus the first digit of the following row
  assign d_hi   = window[{col, 2'b00} +: kmbc_pkg::DIGIT_W];
  assign d_lo   = window[{col, 2'b00} + 6'(kmbc_pkg::DIGIT_W) +: kmbc_pkg::DIGIT_W];
  assign u_calc = (kmbc_pkg::U_W'(d_hi) << 3) + (kmbc_pkg::U_W'(d_hi) << 1)
                + kmbc_pkg::U_W'(d_lo) + kmbc_pkg::U_W'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (rdy0) begin
      v0 <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      u0    <= u_calc;
      kind0 <= din.kind;
      x0    <= din.data_byte;
      last0 <= din.last;
    end
  end

  // stage 1: multiplier select and |x-31| * m
  assign m1   = kind0 ? inv_rom[u0] : u0;
  assign mag1 = (x0 >= kmbc_pkg::BYTE_W'(kmbc_pkg::OFFSET))
              ? x0 - kmbc_pkg::BYTE_W'(kmbc_pkg::OFFSET)
              : kmbc_pkg::BYTE_W'(kmbc_pkg::OFFSET) - x0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && v0) begin
      a1    <= kmbc_pkg::PROD_W'(mag1) * kmbc_pkg::PROD_W'(m1);
      neg1  <= (x0 < kmbc_pkg::BYTE_W'(kmbc_pkg::OFFSET));
      last1 <= last0;
    end
  end

  // stage 2: reciprocal multiply for a / 223
  assign qprod = kmbc_pkg::QPROD_W'(a1) * kmbc_pkg::QPROD_W'(kmbc_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      a2    <= a1;
      q2    <= qprod[kmbc_pkg::RECIP_SHIFT +: kmbc_pkg::BYTE_W];
      neg2  <= neg1;
      last2 <= last1;
    end
  end

  // stage 3: remainder with one correction, sign of the truncated remainder, offset
  assign rem_raw = a2 - kmbc_pkg::PROD_W'(q2) * kmbc_pkg::PROD_W'(kmbc_pkg::MODULUS);
  assign rem3    = (rem_raw >= kmbc_pkg::PROD_W'(kmbc_pkg::MODULUS))
                 ? kmbc_pkg::BYTE_W'(rem_raw - kmbc_pkg::PROD_W'(kmbc_pkg::MODULUS))
                 : kmbc_pkg::BYTE_W'(rem_raw);
  assign res3    = neg2 ? kmbc_pkg::BYTE_W'(kmbc_pkg::OFFSET) - rem3
                        : kmbc_pkg::BYTE_W'(kmbc_pkg::OFFSET) + rem3;

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (rdy3) begin
      dout.valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      dout.out_byte <= res3;
      dout.out_last <= last2;
    end
  end

  `KMBC_ASSERT_ALWAYS(a_col_range, col <= kmbc_pkg::COL_W'(kmbc_pkg::ROW_DIGITS - 1))
  `KMBC_ASSERT_ALWAYS(a_pos_range, pos <= POS_W'(KEY_LENGTH - 1))
  `KMBC_ASSERT_NEXT(a_last_rewinds, accept && din.last, pos == '0 && row == '0 && col == '0)
  `KMBC_ASSERT_ALWAYS(a_quot_close, !v2 || rem_raw < kmbc_pkg::PROD_W'(2 * kmbc_pkg::MODULUS))
  `KMBC_ASSERT_NEXT(a_stage_moves, v2 && rdy3, dout.valid)

endmodule
